>>> hw/rtl/hpt_pkg.sv
// Shared types and constants for the half-precision tanh unit.
// Depends on nothing; every other file in hw/rtl imports it.
package hpt_pkg;

   localparam int HORNER_TERMS = 7;
   localparam int DIV_STEPS    = 25;

   localparam logic [4:0]  EXP_ALL_ONES = 5'd31;
   localparam logic [4:0]  EXP_SATURATE = 5'd18;
   localparam logic [4:0]  EXP_MAIN_MIN = 5'd11;
   localparam logic [14:0] HALF_ONE     = 15'h3C00;
   localparam logic [14:0] QUIET_BIT    = 15'h0200;
   localparam logic [15:0] LN2_Q16      = 16'd45426;
   localparam logic [16:0] ONE_Q16      = 17'h10000;
   localparam logic [14:0] RECIP_LN2    = 15'd23637;    // floor(2^30 / ln2_q16)
   localparam logic [23:0] RECIP_THREE  = 24'd11184811; // ceil(2^25 / 3)

   typedef enum logic [1:0] {
      KIND_SPECIAL,
      KIND_MAIN,
      KIND_SMALL
   } kind_type;

   typedef struct packed {
      logic [15:0] x_bits;
      logic        last_in;
   } req_type;

   typedef struct packed {
      logic [15:0] y_bits;
      logic        last_out;
   } rsp_type;

   // Everything one element carries down the chain.
   typedef struct packed {
      logic        last;
      logic        sign;
      kind_type    kind;
      logic [14:0] spec_mag;
      logic [4:0]  e_exp;
      logic [10:0] mant;
      logic [15:0] r;
      logic [4:0]  n;
      logic [16:0] p;
      logic [31:0] small_r;
      logic [17:0] rem;
      logic [17:0] den;
      logic [24:0] quo;
   } lane_type;

endpackage

>>> hw/rtl/hpt_front.sv
// Front end: decode, range reduction by ln2 and the small-argument series.
// Three pipeline stages. Depends on hpt_pkg.
module hpt_front import hpt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  req_type  in_beat,
   output logic     out_valid,
   input  logic     out_ready,
   output lane_type out_lane
);

   logic        a_valid_ff, b_valid_ff, c_valid_ff;
   logic        a_ready, b_ready, c_ready;
   lane_type    a_lane_in, a_lane_ff, b_lane_in, b_lane_ff, c_lane_in, c_lane_ff;
   logic [19:0] t_a_in, t_a_ff;
   logic [4:0]  n0_a_in, n0_a_ff;
   logic [21:0] mm_a_in, mm_a_ff;
   logic [32:0] cube_b_in, cube_b_ff;
   logic [4:0]  e5;
   logic [9:0]  frac;
   logic [3:0]  t_shift;
   logic [34:0] n0_prod;
   logic [20:0] nl_prod, r0;
   logic [4:0]  c_shift;
   logic [22:0] xs, corr;
   logic [46:0] corr_prod;

   assign c_ready   = !c_valid_ff || out_ready;
   assign b_ready   = !b_valid_ff || c_ready;
   assign a_ready   = !a_valid_ff || b_ready;
   assign in_ready  = a_ready;
   assign out_valid = c_valid_ff;
   assign out_lane  = c_lane_ff;

   // Stage A: classify and start both paths.
   always_comb begin
      e5   = in_beat.x_bits[14:10];
      frac = in_beat.x_bits[9:0];
      a_lane_in      = '0;
      a_lane_in.last = in_beat.last_in;
      a_lane_in.sign = in_beat.x_bits[15];
      priority if (e5 == EXP_ALL_ONES) begin
         a_lane_in.kind     = KIND_SPECIAL;
         a_lane_in.spec_mag = (frac != '0) ? (in_beat.x_bits[14:0] | QUIET_BIT) : HALF_ONE;
      end else if (e5 >= EXP_SATURATE) begin
         a_lane_in.kind     = KIND_SPECIAL;
         a_lane_in.spec_mag = HALF_ONE;
      end else if (e5 >= EXP_MAIN_MIN) begin
         a_lane_in.kind  = KIND_MAIN;
         a_lane_in.e_exp = e5;
         a_lane_in.mant  = {1'b1, frac};
      end else if (e5 == '0) begin
         a_lane_in.kind  = KIND_SMALL;
         a_lane_in.e_exp = 5'd1;
         a_lane_in.mant  = {1'b0, frac};
      end else begin
         a_lane_in.kind  = KIND_SMALL;
         a_lane_in.e_exp = e5;
         a_lane_in.mant  = {1'b1, frac};
      end
      t_shift = 4'(a_lane_in.e_exp - 5'd8);
      t_a_in  = {9'b0, a_lane_in.mant} << t_shift;
      n0_prod = 35'(t_a_in) * 35'(RECIP_LN2);
      n0_a_in = n0_prod[34:30];
      mm_a_in = 22'(a_lane_in.mant) * 22'(a_lane_in.mant);
   end

   // Stage B: correct the quotient estimate by one step, form the cube.
   always_comb begin
      b_lane_in = a_lane_ff;
      nl_prod   = 21'(n0_a_ff) * 21'(LN2_Q16);
      r0        = 21'(t_a_ff) - nl_prod;
      if (r0 >= 21'(LN2_Q16)) begin
         b_lane_in.r = 16'(r0 - 21'(LN2_Q16));
         b_lane_in.n = n0_a_ff + 5'd1;
      end else begin
         b_lane_in.r = 16'(r0);
         b_lane_in.n = n0_a_ff;
      end
      cube_b_in = 33'(mm_a_ff) * 33'(a_lane_ff.mant);
   end

   // Stage C: a - a^3/3 for the small path, seed Horner.
   always_comb begin
      c_lane_in         = b_lane_ff;
      c_shift           = 5'(6'd30 - {b_lane_ff.e_exp, 1'b0});
      xs                = 23'(cube_b_ff >> c_shift);
      corr_prod         = 47'(xs) * 47'(RECIP_THREE);
      corr              = 23'(corr_prod >> 25);
      c_lane_in.small_r = (32'(b_lane_ff.mant) << 20) - 32'(corr);
      c_lane_in.p       = ONE_Q16;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= in_valid;
         if (b_ready) b_valid_ff <= a_valid_ff;
         if (c_ready) c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_lane_ff <= a_lane_in;
         t_a_ff    <= t_a_in;
         n0_a_ff   <= n0_a_in;
         mm_a_ff   <= mm_a_in;
      end
      if (b_ready && a_valid_ff) begin
         b_lane_ff <= b_lane_in;
         cube_b_ff <= cube_b_in;
      end
      if (c_ready && b_valid_ff) c_lane_ff <= c_lane_in;
   end

endmodule

>>> hw/rtl/hpt_horner_cell.sv
// One Horner step of the e^-r series: p = 1 - (r*p)/k, over two stages.
// Depends on hpt_pkg.
module hpt_horner_cell import hpt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic [2:0] k,
   input  logic       in_valid,
   output logic       in_ready,
   input  lane_type   in_lane,
   output logic       out_valid,
   input  logic       out_ready,
   output lane_type   out_lane
);

   // ceil(2^19 / k), exact for every dividend below 2^16
   function automatic logic [19:0] recip(input logic [2:0] kk);
      logic [19:0] m;
      unique case (kk)
         3'd1:    m = 20'd524288;
         3'd2:    m = 20'd262144;
         3'd3:    m = 20'd174763;
         3'd4:    m = 20'd131072;
         3'd5:    m = 20'd104858;
         3'd6:    m = 20'd87382;
         3'd7:    m = 20'd74899;
         default: m = 20'd0;
      endcase
      return m;
   endfunction

   logic        m_valid_ff, o_valid_ff, m_ready, o_ready;
   lane_type    m_lane_ff, o_lane_in, o_lane_ff;
   logic [15:0] x_in, x_ff, q;
   logic [32:0] rp;
   logic [35:0] qp;

   assign o_ready   = !o_valid_ff || out_ready;
   assign m_ready   = !m_valid_ff || o_ready;
   assign in_ready  = m_ready;
   assign out_valid = o_valid_ff;
   assign out_lane  = o_lane_ff;

   always_comb begin
      rp   = 33'(in_lane.r) * 33'(in_lane.p);
      x_in = 16'(rp >> 16);
   end

   always_comb begin
      qp          = 36'(x_ff) * 36'(recip(k));
      q           = 16'(qp >> 19);
      o_lane_in   = m_lane_ff;
      o_lane_in.p = ONE_Q16 - 17'(q);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (m_ready) m_valid_ff <= in_valid;
         if (o_ready) o_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (m_ready && in_valid) begin
         m_lane_ff <= in_lane;
         x_ff      <= x_in;
      end
      if (o_ready && m_valid_ff) o_lane_ff <= o_lane_in;
   end

endmodule

>>> hw/rtl/hpt_div_cell.sv
// One restoring-division step: one quotient bit of num*2^24 / den.
// Depends on hpt_pkg.
module hpt_div_cell import hpt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  lane_type in_lane,
   output logic     out_valid,
   input  logic     out_ready,
   output lane_type out_lane
);

   logic     valid_ff, q_bit;
   lane_type lane_in, lane_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;

   always_comb begin
      q_bit       = (in_lane.rem >= in_lane.den);
      lane_in     = in_lane;
      lane_in.rem = (q_bit ? (in_lane.rem - in_lane.den) : in_lane.rem) << 1;
      lane_in.quo = {in_lane.quo[23:0], q_bit};
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (in_ready) valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) lane_ff <= lane_in;
   end

endmodule

>>> hw/rtl/hpt_back.sv
// Back end: round to binary16, restore the sign, output register.
// Depends on hpt_pkg.
module hpt_back import hpt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  lane_type in_lane,
   output logic     out_valid,
   input  logic     out_ready,
   output rsp_type  out_data
);

   function automatic logic [14:0] pack_half(input logic [31:0] v, input logic sticky,
                                             input logic [4:0] sh, input logic [3:0] expq);
      logic [31:0] kept, rem, half;
      logic        up;
      logic [15:0] sum;
      kept = v >> sh;
      rem  = v & ((32'd1 << sh) - 32'd1);
      half = 32'd1 << (sh - 5'd1);
      up   = (rem > half) || ((rem == half) && (sticky || kept[0]));
      sum  = 16'({expq, 10'b0}) + 16'(kept) + 16'(up) - 16'd1024;
      return sum[14:0];
   endfunction

   logic        valid_ff;
   rsp_type     data_in, data_ff;
   logic [4:0]  mb, s_top, s_lim, s_hi;
   logic [14:0] mag;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      priority if (in_lane.quo[24]) mb = 5'd24;
      else if (in_lane.quo[23])     mb = 5'd23;
      else if (in_lane.quo[22])     mb = 5'd22;
      else if (in_lane.quo[21])     mb = 5'd21;
      else if (in_lane.quo[20])     mb = 5'd20;
      else                          mb = 5'd19;
      s_top = in_lane.small_r[30] ? 5'd30 : 5'd29;
      s_lim = 5'd31 - in_lane.e_exp;
      s_hi  = (s_top > s_lim) ? s_top : s_lim;
      unique case (in_lane.kind)
         KIND_MAIN:
            mag = pack_half(32'(in_lane.quo), in_lane.rem != '0, mb - 5'd10, 4'(mb - 5'd9));
         KIND_SMALL:
            mag = (in_lane.small_r == '0) ? 15'd0 :
                  pack_half(in_lane.small_r, 1'b0, s_hi - 5'd10,
                            4'(s_hi + in_lane.e_exp - 5'd30));
         default: mag = in_lane.spec_mag;
      endcase
      data_in.y_bits   = {in_lane.sign, mag};
      data_in.last_out = in_lane.last;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (in_ready) valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) data_ff <= data_in;
   end

endmodule

>>> hw/rtl/half_precision_tanh_unit.sv
// Half-precision tanh unit: top level of the element pipeline.
// Depends on hpt_pkg, hpt_front, hpt_horner_cell, hpt_div_cell and hpt_back.
//
// The unit takes one binary16 value per beat and returns tanh of it, rounded
// to nearest even, with the last-of-tile mark copied alongside. It accepts a
// beat every cycle and returns one every cycle when the result side is not
// stalled; each beat passes 43 register stages from acceptance to result:
// 3 front-end stages, 7 Horner cells of 2 stages each, 25 division cells and
// the output register. Every stage holds its own valid bit, so bubbles close
// up while the result side stalls and beats keep entering until the chain is
// full. Large finite inputs and infinities give +1 or -1; NaN comes back
// quietened with sign and payload kept; signed zero is preserved.
module half_precision_tanh_unit import hpt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic     front_ready;
   logic     hor_valid [0:HORNER_TERMS];
   logic     hor_ready [0:HORNER_TERMS];
   lane_type hor_lane  [0:HORNER_TERMS];
   logic     div_valid [0:DIV_STEPS];
   logic     div_ready [0:DIV_STEPS];
   lane_type div_lane  [0:DIV_STEPS];
   logic [16:0] u;

   assign req_stall = !front_ready;

   hpt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .in_beat   (req_data),
      .out_valid (hor_valid[0]),
      .out_ready (hor_ready[0]),
      .out_lane  (hor_lane[0])
   );

   // Horner cells run k = 7 down to 1, each passing p on to the next.
   for (genvar i = 0; i < HORNER_TERMS; i++) begin : g_horner
      hpt_horner_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .k         (3'(HORNER_TERMS - i)),
         .in_valid  (hor_valid[i]),
         .in_ready  (hor_ready[i]),
         .in_lane   (hor_lane[i]),
         .out_valid (hor_valid[i+1]),
         .out_ready (hor_ready[i+1]),
         .out_lane  (hor_lane[i+1])
      );
   end

   // Scale e^-r by 2^-n, then set up (1 - u) / (1 + u) for the divider.
   always_comb begin
      u                = hor_lane[HORNER_TERMS].p >> hor_lane[HORNER_TERMS].n;
      div_lane[0]      = hor_lane[HORNER_TERMS];
      div_lane[0].rem  = 18'(ONE_Q16 - u);
      div_lane[0].den  = 18'(ONE_Q16) + 18'(u);
      div_lane[0].quo  = '0;
   end
   assign div_valid[0]            = hor_valid[HORNER_TERMS];
   assign hor_ready[HORNER_TERMS] = div_ready[0];

   // One quotient bit per cell, most significant first.
   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      hpt_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[j]),
         .in_ready  (div_ready[j]),
         .in_lane   (div_lane[j]),
         .out_valid (div_valid[j+1]),
         .out_ready (div_ready[j+1]),
         .out_lane  (div_lane[j+1])
      );
   end

   hpt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid[DIV_STEPS]),
      .in_ready  (div_ready[DIV_STEPS]),
      .in_lane   (div_lane[DIV_STEPS]),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   // Input can only back up when every stage is full and the output stalls.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while the chain has room");

   // A quotient of exactly one leaves no lower bits and no remainder.
   a_quotient_one_exact: assert property (@(posedge clock) disable iff (reset)
      (div_valid[DIV_STEPS] && div_lane[DIV_STEPS].kind == KIND_MAIN &&
       div_lane[DIV_STEPS].quo[24])
      |-> (div_lane[DIV_STEPS].quo[23:0] == '0 && div_lane[DIV_STEPS].rem == '0))
      else $error("quotient above one");

   // tanh on the main range is at least 2^-5, so the leading one is high.
   a_quotient_range: assert property (@(posedge clock) disable iff (reset)
      (div_valid[DIV_STEPS] && div_lane[DIV_STEPS].kind == KIND_MAIN)
      |-> (div_lane[DIV_STEPS].quo[24:19] != '0))
      else $error("main-path quotient below range");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");
`endif

endmodule

>>> tb/hpt_checker.sv
// Checker for the half-precision tanh unit: predicts tanh of every accepted beat.
// Depends on hpt_pkg; compares each result beat against the oldest prediction.
module hpt_checker import hpt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending
);

   rsp_type tanh_queue[$];

   function automatic logic [14:0] round_half(longint unsigned v, bit sticky, int p);
      int b;
      int e;
      int q;
      int sh;
      longint unsigned kept;
      longint unsigned rem;
      longint unsigned half;
      b = 0;
      if (v == 0) return 15'd0;
      while (b < 63 && (v >> (b + 1)) != 0) b++;
      e = b + p;
      q = ((e < -14) ? -14 : e) - 10;
      sh = q - p;
      if (sh <= 0) begin
         kept = v;
      end else begin
         kept = v >> sh;
         rem = v & ((64'd1 << sh) - 1);
         half = 64'd1 << (sh - 1);
         if (rem > half || (rem == half && (sticky || kept[0]))) kept++;
      end
      return 15'((longint'(q + 25) << 10) + kept - 1024);
   endfunction

   function automatic logic [14:0] tanh_exp_path(longint unsigned m, int e);
      longint unsigned t;
      longint unsigned n;
      longint unsigned r;
      longint unsigned p;
      longint unsigned u;
      longint unsigned num;
      longint unsigned den;
      t = m << (e - 8);
      n = t / LN2_Q16;
      r = t - n * LN2_Q16;
      p = ONE_Q16;
      for (int k = HORNER_TERMS; k >= 1; k--) p = ONE_Q16 - (((r * p) >> 16) / k);
      u = (n < 63) ? (p >> n) : 0;
      num = ONE_Q16 - u;
      den = ONE_Q16 + u;
      return round_half((num << 24) / den, ((num << 24) % den) != 0, -24);
   endfunction

   function automatic logic [14:0] tanh_series(longint unsigned m, int e);
      longint unsigned corr;
      corr = ((m * m * m) >> (30 - 2 * e)) / 3;
      return round_half((m << 20) - corr, 1'b0, e - 45);
   endfunction

   function automatic logic [15:0] predict_tanh(logic [15:0] x);
      logic [4:0]  ex;
      logic [9:0]  fr;
      logic [14:0] mag;
      ex = x[14:10];
      fr = x[9:0];
      if (ex == EXP_ALL_ONES)      mag = (fr != 0) ? ((x[14:0] | QUIET_BIT)) : HALF_ONE;
      else if (ex >= EXP_SATURATE) mag = HALF_ONE;
      else if (ex >= EXP_MAIN_MIN) mag = tanh_exp_path({1'b1, fr}, ex);
      else if (ex == 0)            mag = tanh_series(fr, 1);
      else                         mag = tanh_series({1'b1, fr}, ex);
      return {x[15], mag};
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         fail_count <= 0;
         tanh_queue.delete();
         pending <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (tanh_queue.size() == 0) begin
               $display("%0t unexpected result beat %h", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = tanh_queue.pop_front();
               if (rsp_data.y_bits !== want.y_bits || rsp_data.last_out !== want.last_out) begin
                  $display("%0t mismatch: expected y=%h last=%b, actual y=%h last=%b",
                     $time, want.y_bits, want.last_out, rsp_data.y_bits, rsp_data.last_out);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall)
            tanh_queue.push_back('{predict_tanh(req_data.x_bits), req_data.last_in});
         pending <= tanh_queue.size();
      end
   end

endmodule

>>> tb/testbench.sv
// Top of the tanh unit bench: clock, reset, stimulus and the verdict.
// Depends on hpt_pkg, half_precision_tanh_unit and hpt_checker.
module testbench;
   import hpt_pkg::*;

   localparam int LATENCY   = 43;
   localparam int RAND_BEATS = 1000;
   localparam int CYCLE_LIMIT = 200000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;
   int      cycle_count = 0;

   always #2 clock = ~clock;

   half_precision_tanh_unit u_top (.*);

   hpt_checker u_checker (.*);

   // Timeout: count every rising edge and give up far beyond the slowest run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[half_precision_tanh_unit] ERROR");
         $finish;
      end
   end

   // Receiver: stall in runs of a random length, with quiet stretches too.
   initial begin
      int run;
      forever begin
         run = $urandom_range(1, 30);
         repeat (run) begin
            @(negedge clock);
            rsp_stall <= ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 2) == 0) : 1'b0;
         end
         run = $urandom_range(0, 8);
         repeat (run) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
      end
   end

   // Present one beat at a falling edge; hold until accepted at a rising edge.
   task automatic send_beat(logic [15:0] x, logic last);
      req_valid <= 1'b1;
      req_data  <= '{x, last};
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic idle_gap(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Pick a value biased towards the interesting exponent bands.
   function automatic logic [15:0] random_half();
      logic [4:0] ex;
      case ($urandom_range(0, 9))
         0:       ex = 5'd0;
         1:       ex = EXP_ALL_ONES;
         2:       ex = 5'($urandom_range(18, 30));
         3, 4:    ex = 5'($urandom_range(1, 10));
         default: ex = 5'($urandom_range(11, 17));
      endcase
      return {1'($urandom_range(0, 1)), ex, 10'($urandom_range(0, 1023))};
   endfunction

   initial begin
      logic [15:0] directed[$];
      int burst;
      int beats;
      directed = '{16'h0000, 16'h8000, 16'h0001, 16'h83FF, 16'h0400, 16'h2BFF,
                   16'h2C00, 16'hAC00, 16'h3C00, 16'hBC00, 16'h47FF, 16'hC7FF,
                   16'h4800, 16'hC800, 16'h7BFF, 16'hFBFF, 16'h7C00, 16'hFC00,
                   16'h7C01, 16'hFE00, 16'h7DFF, 16'hFFFF, 16'h3555, 16'h4000};
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (directed[i]) send_beat(directed[i], i[0]);
      idle_gap(1);
      // Drain completely once before the random part.
      while (pending != 0) @(negedge clock);
      beats = 0;
      while (beats < RAND_BEATS) begin
         burst = $urandom_range(1, 40);
         repeat (burst) begin
            send_beat(random_half(), 1'($urandom_range(0, 1)));
            beats++;
         end
         if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 6));
      end
      idle_gap(1);
      while (pending != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("[half_precision_tanh_unit] OK");
      end else begin
         $display("[half_precision_tanh_unit] ERROR");
      end
      $finish;
   end

endmodule
